[hdl/irbs_pkg.sv]
// Shared types and constants for the IPv4 range lookup block.
// Used by irbs_ctrl, irbs_dpath and ip_range_binary_search_lookup.
package irbs_pkg;

   // Defaults for the top-level parameters
   localparam int DEF_RECORD_DEPTH = 1048576;
   localparam int DEF_MAX_STEPS    = 23;

   // Word kinds on the request side (req_tuser)
   localparam logic [1:0] MODE_INDEX  = 2'd0;
   localparam logic [1:0] MODE_RECORD = 2'd1;
   localparam logic [1:0] MODE_QUERY  = 2'd2;
   localparam logic [1:0] MODE_NONE   = 2'd3;

   // Result codes on the response side (rsp_tuser)
   localparam logic [1:0] STATUS_FOUND  = 2'd0;
   localparam logic [1:0] STATUS_MISS   = 2'd1;
   localparam logic [1:0] STATUS_LOADED = 2'd2;

   // Register indexes on the csr port
   localparam logic CSR_RECORD_COUNT = 1'b0;
   localparam logic CSR_TEXT_BASE    = 1'b1;

   localparam int CSR_DATA_W = 32;
   localparam int REQ_DATA_W = 120;
   localparam int RSP_DATA_W = 64;

   // Request word layout
   localparam int SLOT_LSB   = 0;
   localparam int SLOT_W     = 23;
   localparam int ADDR_LSB   = 23;
   localparam int START_LSB  = 55;
   localparam int START_W    = 24;
   localparam int OFFSET_LSB = 79;
   localparam int LENGTH_LSB = 111;

   localparam int BOUND_W = 25;          // search bounds, one above a 24-bit index value
   localparam logic [7:0] LAST_OCTET = 8'hFF;
   localparam logic [7:0] PREV_OCTET = 8'hFE;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_IDX_LO,
      ST_IDX_HI,
      ST_BOUND,
      ST_MID,
      ST_CMP,
      ST_DONE_LOAD,
      ST_DONE_MISS,
      ST_DONE_HIT
   } state_type;

   typedef struct packed {
      logic       accept;     // request word taken this cycle
      logic       set_left;   // left bound from the first index read
      logic       set_right;  // right bound from the second index read
      logic       find;       // latch middle and its range-end read
      logic       cmp;        // narrow bounds on the range-end compare
      logic       emit;       // load the response register
      logic [1:0] status;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic at_limit;
      logic mid_hit;
   } sts_type;

endpackage

[hdl/ip_range_binary_search_lookup.sv]
// IPv4 range lookup by binary search over a sorted record table.
// Loads: the response is loaded from DONE_LOAD; the next word is taken back in IDLE.
// Query: states IDX_LO, IDX_HI, BOUND, then halving steps of a record read, then a compare,
// until the middle meets the left bound (found) or all 23 steps run out (miss).
// One word at a time; the response register frees the input while a word waits.
// Synchronous reset clears the csr registers, sequencer and response valid.
module ip_range_binary_search_lookup #(
   parameter int RECORD_DEPTH = irbs_pkg::DEF_RECORD_DEPTH,
   parameter int MAX_STEPS    = irbs_pkg::DEF_MAX_STEPS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [1:0]                       req_tuser,   // mode
   // slot, address, start_record, text_offset, text_length, pad
   input  logic [irbs_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [1:0]                       rsp_tuser,   // status
   // text_address, text_bytes, match_record, pad
   output logic [irbs_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                             csr_we,
   input  logic                             csr_addr,
   input  logic [irbs_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import irbs_pkg::*;

   cmd_type   cmd;
   sts_type   sts;
   state_type state;

   irbs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_mode   (req_tuser),
      .sts        (sts),
      .cmd        (cmd),
      .state      (state)
   );

   irbs_dpath #(
      .RECORD_DEPTH (RECORD_DEPTH),
      .MAX_STEPS    (MAX_STEPS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_mode   (req_tuser),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

   // response register is never overwritten while a word waits in it
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_tvalid || rsp_tready))
      else $error("response overwritten while pending");

   // one word in flight: no accept right after an accept
   a_one_word: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second word taken while busy");

   // a new response only follows an emit command
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(cmd.emit))
      else $error("response valid without emit");

   // the search compare only runs right after a middle read
   a_cmp_order: assert property (@(posedge clock) disable iff (reset)
      cmd.cmp |-> ($past(cmd.find) && state == ST_CMP))
      else $error("compare without middle read");

endmodule

[hdl/irbs_ctrl.sv]
// Sequencer for the IPv4 range lookup: decodes word kinds and steps the search.
// Depends on irbs_pkg; drives irbs_dpath through cmd_type, reads sts_type.
module irbs_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [1:0]        req_mode,
   input  irbs_pkg::sts_type sts,
   output irbs_pkg::cmd_type cmd,
   output irbs_pkg::state_type state
);
   import irbs_pkg::*;

   state_type state_ff, state_in;

   assign state = state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               case (req_mode)
                  MODE_INDEX:  state_in = ST_DONE_LOAD;
                  MODE_RECORD: state_in = ST_DONE_LOAD;
                  MODE_QUERY:  state_in = ST_IDX_LO;
                  default:     state_in = ST_DONE_MISS;
               endcase
            end
         end
         ST_IDX_LO: state_in = ST_IDX_HI;
         ST_IDX_HI: state_in = ST_BOUND;
         ST_BOUND:  state_in = ST_MID;
         ST_MID: begin
            if (sts.at_limit) begin
               state_in = ST_DONE_MISS;
            end else if (sts.mid_hit) begin
               state_in = ST_DONE_HIT;
            end else begin
               state_in = ST_CMP;
            end
         end
         ST_CMP: state_in = ST_MID;
         ST_DONE_LOAD, ST_DONE_MISS, ST_DONE_HIT: begin
            if (sts.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      cmd        = '0;
      cmd.status = STATUS_MISS;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
         end
         ST_IDX_HI: cmd.set_left  = 1'b1;
         ST_BOUND:  cmd.set_right = 1'b1;
         ST_MID:    cmd.find = !sts.at_limit && !sts.mid_hit;
         ST_CMP:    cmd.cmp  = 1'b1;
         ST_DONE_LOAD: begin
            cmd.emit   = sts.out_free;
            cmd.status = STATUS_LOADED;
         end
         ST_DONE_MISS: begin
            cmd.emit   = sts.out_free;
            cmd.status = STATUS_MISS;
         end
         ST_DONE_HIT: begin
            cmd.emit   = sts.out_free;
            cmd.status = STATUS_FOUND;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

endmodule

[hdl/irbs_dpath.sv]
// Datapath of the IPv4 range lookup: csr registers, index and record stores,
// search bounds and the response register. Depends on irbs_pkg.
module irbs_dpath #(
   parameter int RECORD_DEPTH = irbs_pkg::DEF_RECORD_DEPTH,
   parameter int MAX_STEPS    = irbs_pkg::DEF_MAX_STEPS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [1:0]                       req_mode,
   input  logic [irbs_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                             csr_we,
   input  logic                             csr_addr,
   input  logic [irbs_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  irbs_pkg::cmd_type                cmd,
   output irbs_pkg::sts_type                sts,
   input  logic                             rsp_tready,
   output logic                             rsp_tvalid,
   output logic [1:0]                       rsp_tuser,
   output logic [irbs_pkg::RSP_DATA_W-1:0]  rsp_tdata
);
   import irbs_pkg::*;

   localparam int ADDR_W = $clog2(RECORD_DEPTH);
   localparam int STEP_W = $clog2(MAX_STEPS + 1);
   localparam logic [BOUND_W-1:0] DEPTH_V = BOUND_W'(RECORD_DEPTH);

   // request fields
   logic [SLOT_W-1:0]  slot;
   logic [31:0]        address;
   logic [START_W-1:0] start_record;
   logic [31:0]        text_offset;
   logic [7:0]         text_length;

   assign slot         = req_tdata[SLOT_LSB +: SLOT_W];
   assign address      = req_tdata[ADDR_LSB +: 32];
   assign start_record = req_tdata[START_LSB +: START_W];
   assign text_offset  = req_tdata[OFFSET_LSB +: 32];
   assign text_length  = req_tdata[LENGTH_LSB +: 8];

   logic [23:0] record_count_ff;
   logic [31:0] text_base_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         record_count_ff <= '0;
         text_base_ff    <= '0;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_RECORD_COUNT: record_count_ff <= csr_wdata[23:0];
            CSR_TEXT_BASE:    text_base_ff    <= csr_wdata;
            default:          text_base_ff    <= text_base_ff;
         endcase
      end
   end

   // stores
   logic [START_W-1:0] idx_mem [0:255];
   logic [31:0]        end_mem [0:RECORD_DEPTH-1];
   logic [39:0]        text_mem [0:RECORD_DEPTH-1];

   logic [31:0]        ip_ff;
   logic [BOUND_W-1:0] left_ff, right_ff, mid_ff;
   logic [STEP_W-1:0]  step_ff;
   logic [START_W-1:0] idx_rd_ff;
   logic [31:0]        end_rd_ff;
   logic [39:0]        text_rd_ff;

   logic [7:0]         first;
   logic               last_octet;
   logic [7:0]         idx_addr;
   logic [BOUND_W:0]   sum;
   logic [BOUND_W-1:0] mid;
   logic               idx_wr, rec_wr;

   assign first      = ip_ff[31:24];
   assign last_octet = (first == LAST_OCTET);
   assign sum        = {1'b0, left_ff} + {1'b0, right_ff};
   assign mid        = sum[BOUND_W:1];
   assign idx_wr     = cmd.accept && (req_mode == MODE_INDEX) && (slot[SLOT_W-1:8] == '0);
   assign rec_wr     = cmd.accept && (req_mode == MODE_RECORD)
                       && ({2'b00, slot} < DEPTH_V);

   // first read takes the slot's own entry (slot 254 for the last octet), second the next one
   always_comb begin
      if (cmd.set_left) begin
         idx_addr = first + 8'd1;
      end else begin
         idx_addr = last_octet ? PREV_OCTET : first;
      end
   end

   always_ff @(posedge clock) begin
      if (idx_wr) begin
         idx_mem[slot[7:0]] <= start_record;
      end
      idx_rd_ff <= idx_mem[idx_addr];
   end

   always_ff @(posedge clock) begin
      if (rec_wr) begin
         end_mem[slot[ADDR_W-1:0]]  <= address;
         text_mem[slot[ADDR_W-1:0]] <= {text_length, text_offset};
      end
      end_rd_ff  <= end_mem[mid[ADDR_W-1:0]];
      text_rd_ff <= text_mem[right_ff[ADDR_W-1:0]];
   end

   // search bounds
   logic [31:0] end_val;
   assign end_val = (mid_ff < DEPTH_V) ? end_rd_ff : 32'd0;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         ip_ff <= address;
      end
      if (cmd.set_left) begin
         left_ff <= {1'b0, idx_rd_ff} + {{(BOUND_W-1){1'b0}}, last_octet};
      end
      if (cmd.set_right) begin
         step_ff <= '0;
         if (last_octet || (idx_rd_ff < 24'd2)) begin
            right_ff <= {1'b0, record_count_ff};
         end else begin
            right_ff <= {1'b0, idx_rd_ff} - 25'd1;
         end
      end
      if (cmd.find) begin
         mid_ff <= mid;
      end
      if (cmd.cmp) begin
         step_ff <= step_ff + 1'b1;
         if (ip_ff <= end_val) begin
            right_ff <= mid_ff;
         end else begin
            left_ff <= mid_ff;
         end
      end
   end

   // response register
   logic        rsp_valid_ff;
   logic [1:0]  rsp_status_ff;
   logic [31:0] rsp_addr_ff;
   logic [7:0]  rsp_bytes_ff;
   logic [22:0] rsp_rec_ff;
   logic        right_ok;

   assign right_ok = (right_ff < DEPTH_V);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_status_ff <= cmd.status;
         if (cmd.status == STATUS_FOUND) begin
            rsp_addr_ff  <= text_base_ff + (right_ok ? text_rd_ff[31:0] : 32'd0);
            rsp_bytes_ff <= right_ok ? text_rd_ff[39:32] : 8'd0;
            rsp_rec_ff   <= right_ff[22:0];
         end else begin
            rsp_addr_ff  <= '0;
            rsp_bytes_ff <= '0;
            rsp_rec_ff   <= '0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {1'b0, rsp_rec_ff, rsp_bytes_ff, rsp_addr_ff};

   assign sts.out_free = !rsp_valid_ff || rsp_tready;
   assign sts.at_limit = (step_ff == STEP_W'(MAX_STEPS));
   assign sts.mid_hit  = (mid == left_ff);

endmodule

[sim/ip_range_binary_search_lookup_test.sv]
`timescale 1ns / 100ps
// Testbench for ip_range_binary_search_lookup: loads octet index slots and sorted range
// records, runs address lookups and checks every response word against a local predictor.
// Depends on irbs_pkg and the RTL under hdl/.
module ip_range_binary_search_lookup_test;
   import irbs_pkg::*;

   localparam int DEPTH        = DEF_RECORD_DEPTH;
   localparam int STEPS        = DEF_MAX_STEPS;
   localparam int INDEX_SLOTS  = 256;
   localparam int DRAIN_CYCLES = 60;

   typedef struct packed {
      logic        pad;
      logic [7:0]  length;
      logic [31:0] offset;
      logic [23:0] start;
      logic [31:0] address;
      logic [22:0] slot;
   } req_word_type;

   typedef struct packed {
      logic        pad;
      logic [22:0] record_num;
      logic [7:0]  bytes;
      logic [31:0] addr;
   } rsp_word_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] addr;
      logic [7:0]  bytes;
      logic [22:0] record_num;
   } lookup_type;

   typedef struct packed {
      logic [31:0] range_end;
      logic [31:0] offset;
      logic [7:0]  length;
   } record_type;

   typedef struct packed {
      logic [1:0]   mode;
      req_word_type word;
   } load_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [1:0]            req_tuser  = MODE_NONE;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [1:0]            rsp_tuser;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we     = 1'b0;
   logic                  csr_addr   = CSR_RECORD_COUNT;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   // predictor copy of the lookup tables and registers
   logic [23:0] octet_start [INDEX_SLOTS] = '{default: '0};
   bit          octet_loaded [INDEX_SLOTS];
   record_type  record_table [int];
   logic [23:0] count_reg = '0;
   logic [31:0] base_reg  = '0;

   lookup_type pending_results [$];
   int      mismatches  = 0;
   int      words_sent  = 0;
   int      loads_seen  = 0;
   int      found_seen  = 0;
   int      missed_seen = 0;
   int      csr_writes  = 0;
   int      ready_hold  = 0;
   bit      idle_on     = 1'b1;

   ip_range_binary_search_lookup DUT (.*);

   always #10 clock = ~clock;

   initial begin
      #20_000_000;
      $display("ip_range_binary_search_lookup: mismatch");
      $finish;
   end

   // legal is cleared when the search would read a slot or record never loaded
   function automatic lookup_type predict_lookup(input logic [31:0] ip, output bit legal);
      int unsigned left, right, middle, nxt;
      logic [7:0]  first;
      logic [31:0] end_val;
      lookup_type  r;
      int          step;
      r = '0;
      r.status = STATUS_MISS;
      first = ip[31:24];
      if (first == LAST_OCTET) begin
         legal = octet_loaded[PREV_OCTET];
         left  = 32'(octet_start[PREV_OCTET]) + 1;
         right = 32'(count_reg);
      end else begin
         legal = octet_loaded[first] && octet_loaded[first + 8'd1];
         nxt   = 32'(octet_start[first + 8'd1]);
         left  = 32'(octet_start[first]);
         right = (nxt >= 2) ? nxt - 1 : 32'(count_reg);
      end
      for (step = 0; step < STEPS; step++) begin
         middle = (left + right) >> 1;
         if (middle == left) begin
            r.status     = STATUS_FOUND;
            r.record_num = right[22:0];
            r.addr       = base_reg;
            if (right < DEPTH) begin
               legal &= record_table.exists(int'(right));
               if (record_table.exists(int'(right))) begin
                  r.addr  = base_reg + record_table[int'(right)].offset;
                  r.bytes = record_table[int'(right)].length;
               end
            end
            return r;
         end
         end_val = '0;
         if (middle < DEPTH) begin
            legal &= record_table.exists(int'(middle));
            if (record_table.exists(int'(middle)))
               end_val = record_table[int'(middle)].range_end;
         end
         if (ip <= end_val) right = middle;
         else left = middle;
      end
      return r;
   endfunction

   function automatic req_word_type random_word();
      req_word_type w;
      logic [127:0] bits;
      bits  = {$urandom, $urandom, $urandom, $urandom};
      w     = bits[119:0];
      w.pad = 1'b0;
      return w;
   endfunction

   task automatic note_mismatch(input string what);
      mismatches++;
      if (mismatches <= 10) $display("%0t ns: %s", $time, what);
   endtask

   task automatic send_word(input logic [1:0] mode, input req_word_type w);
      lookup_type want;
      bit         legal;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= w;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      want = '0;
      want.status = STATUS_LOADED;
      case (mode)
         MODE_INDEX: begin
            if (32'(w.slot) < INDEX_SLOTS) begin
               octet_start[w.slot[7:0]]  = w.start;
               octet_loaded[w.slot[7:0]] = 1'b1;
            end
         end
         MODE_RECORD: begin
            if (32'(w.slot) < DEPTH)
               record_table[int'(w.slot)] = '{w.address, w.offset, w.length};
         end
         MODE_QUERY: want = predict_lookup(w.address, legal);
         default: want.status = STATUS_MISS;
      endcase
      pending_results.push_back(want);
      words_sent++;
   endtask

   task automatic send_query(input logic [31:0] ip, output bit sent);
      req_word_type w;
      lookup_type   unused;
      bit           legal;
      unused = predict_lookup(ip, legal);
      sent = legal;
      if (legal) begin
         w = random_word();
         w.address = ip;
         send_word(MODE_QUERY, w);
      end
   endtask

   task automatic load_record(input int num, input logic [31:0] range_end,
                              input logic [31:0] offset, input logic [7:0] length);
      req_word_type w;
      w = random_word();
      w.slot    = 23'(num);
      w.address = range_end;
      w.offset  = offset;
      w.length  = length;
      send_word(MODE_RECORD, w);
   endtask

   task automatic load_index(input int slot, input logic [23:0] start);
      req_word_type w;
      w = random_word();
      w.slot  = 23'(slot);
      w.start = start;
      send_word(MODE_INDEX, w);
   endtask

   task automatic csr_write(input logic idx, input logic [31:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      if (idx == CSR_RECORD_COUNT) count_reg = value[23:0];
      else base_reg = value;
      csr_writes++;
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // receiver stalls in random bursts while idle_on is set
   always @(posedge clock) begin
      if (ready_hold != 0) begin
         rsp_tready <= 1'b0;
         ready_hold <= ready_hold - 1;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
         rsp_tready <= 1'b0;
         ready_hold <= $urandom_range(0, 15);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      rsp_word_type got;
      lookup_type   want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         case (rsp_tuser)
            STATUS_FOUND:  found_seen++;
            STATUS_LOADED: loads_seen++;
            default:       missed_seen++;
         endcase
         if (pending_results.size() == 0) begin
            note_mismatch($sformatf("response word with nothing pending: status %0d tdata %h",
                                    rsp_tuser, rsp_tdata));
         end else begin
            want = pending_results.pop_front();
            if (rsp_tuser !== want.status || got.addr !== want.addr ||
                got.bytes !== want.bytes || got.record_num !== want.record_num)
               note_mismatch($sformatf({"exp/got status %0d/%0d text_address %h/%h ",
                                        "text_bytes %0d/%0d match_record %0d/%0d"},
                                       want.status, rsp_tuser, want.addr, got.addr,
                                       want.bytes, got.bytes, want.record_num,
                                       got.record_num));
         end
      end
   end

   task automatic test_directed_cases();
      req_word_type w;
      bit           sent;
      csr_write(CSR_RECORD_COUNT, 32'd4);
      csr_write(CSR_TEXT_BASE, 32'hFFFF_FFF0);    // text address wraps
      load_record(0, 32'h0000_0000, 32'h0000_0000, 8'd0);
      load_record(1, 32'h0080_0000, 32'h0000_0020, 8'hFF);
      load_record(2, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h80);
      load_record(3, 32'hFFFF_FFFF, 32'h0000_0005, 8'd1);
      // record numbers past the store are dropped
      load_record(DEPTH, 32'h1234_5678, 32'hDEAD_BEEF, 8'h55);
      load_record(23'h7F_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
      load_index(0, 24'd0);
      load_index(1, 24'd1);                        // next slot 1: right from record_count
      load_index(254, 24'd0);
      load_index(255, 24'hFF_FFFF);
      load_index(10, 24'h80_0005);                 // match above 23 bits
      load_index(11, 24'h80_0007);
      load_index(256, 24'h12_3456);                // slots past 255 are dropped
      load_index(23'h7F_FFFF, 24'hFF_FFFF);
      w = random_word();
      send_word(MODE_NONE, w);
      send_query(32'h0000_0000, sent);
      send_query(32'h0080_0000, sent);
      send_query(32'h0080_0001, sent);
      send_query(32'hFFFF_FFFF, sent);             // last octet bounds
      send_query(32'hFF00_0000, sent);
      send_query(32'hFE12_3456, sent);             // runs out of halving steps
      send_query(32'h0A00_0001, sent);
   endtask

   task automatic test_config_extremes();
      bit sent;
      wait_idle();
      csr_write(CSR_RECORD_COUNT, 32'd0);
      csr_write(CSR_TEXT_BASE, 32'd0);
      send_query(32'hFFFF_FFFF, sent);             // left above right
      wait_idle();
      csr_write(CSR_RECORD_COUNT, 32'hFFFF_FFFF);
      csr_write(CSR_TEXT_BASE, 32'hFFFF_FFFF);
      send_query(32'hFF80_0000, sent);
   endtask

   task automatic test_random_tables(input int phases, input int queries);
      int unsigned  n, rbase, o0, ocnt, stride, cnt, sent_q, tries, j;
      logic [31:0]  ends [$];
      load_type     loads [$];
      logic [31:0]  cur, ip, count_val, base_val;
      req_word_type w;
      bit           ok;
      for (int p = 0; p < phases; p++) begin
         wait_idle();
         idle_on = (p != phases - 1) && (p % 3 != 2);
         n     = $urandom_range(2, 24);
         rbase = ($urandom_range(0, 3) == 0) ? DEPTH - $urandom_range(1, 30)
                                              : $urandom_range(0, 300);
         o0    = ($urandom_range(0, 3) == 0) ? $urandom_range(248, 254) : $urandom_range(0, 247);
         ocnt  = $urandom_range(1, (255 - o0 < 4) ? 255 - o0 : 4);
         case ($urandom_range(0, 4))
            0:       count_val = 32'd0;
            1:       count_val = 32'hFFFF_FFFF;
            2:       count_val = rbase + n;
            default: count_val = rbase + n - 1;
         endcase
         case ($urandom_range(0, 3))
            0:       base_val = 32'd0;
            1:       base_val = 32'hFFFF_FFFF;
            default: base_val = $urandom;
         endcase
         csr_write(CSR_RECORD_COUNT, count_val);
         csr_write(CSR_TEXT_BASE, base_val);

         // sorted range ends spread over the table's octets
         ends.delete();
         cur    = {o0[7:0], 24'd0};
         stride = (ocnt << 24) / n;
         for (int i = 0; i < n; i++) begin
            cur = cur + ((i == 0) ? $urandom_range(0, stride) : $urandom_range(1, stride));
            ends.push_back(cur);
         end
         loads.delete();
         for (int i = 0; i < n; i++) begin
            w = random_word();
            w.slot    = 23'(rbase + i);
            w.address = ends[i];
            loads.push_back('{MODE_RECORD, w});
         end
         for (int unsigned k = o0; k <= o0 + ocnt; k++) begin
            cnt = rbase;
            foreach (ends[i]) if (ends[i] < {k[7:0], 24'd0}) cnt++;
            if ($urandom_range(0, 9) == 0) cnt = $urandom_range(0, 1);
            w = random_word();
            w.slot  = 23'(k);
            w.start = 24'(cnt);
            loads.push_back('{MODE_INDEX, w});
         end
         while (loads.size() != 0) begin
            j = $urandom_range(0, loads.size() - 1);
            send_word(loads[j].mode, loads[j].word);
            loads.delete(j);
         end

         sent_q = 0;
         tries  = 0;
         while (sent_q < queries && tries < queries * 8) begin
            tries++;
            j = $urandom_range(0, n - 1);
            case ($urandom_range(0, 7))
               0:       ip = ends[j];
               1:       ip = ends[j] + 1;
               2:       ip = ends[j] - 1;
               3:       ip = $urandom;
               4:       ip = ($urandom_range(0, 1) == 0) ? 32'h0 : 32'hFFFF_FFFF;
               default: ip = {8'(o0 + $urandom_range(0, ocnt)), 24'($urandom)};
            endcase
            if ($urandom_range(0, 11) == 0) begin
               w = random_word();
               case ($urandom_range(0, 2))
                  0: begin
                     w.slot = 23'($urandom_range(INDEX_SLOTS, 23'h7F_FFFF));
                     send_word(MODE_INDEX, w);
                  end
                  1: begin
                     w.slot = 23'($urandom_range(DEPTH, 23'h7F_FFFF));
                     send_word(MODE_RECORD, w);
                  end
                  default: send_word(MODE_NONE, w);
               endcase
            end
            send_query(ip, ok);
            if (ok) sent_q++;
         end
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_config_extremes();
      test_random_tables(6, 50);
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d request words across %0d register writes", words_sent, csr_writes);
      $display("Responses: %0d loads, %0d found, %0d not found; %0d bad words",
               loads_seen, found_seen, missed_seen, mismatches);
      if (mismatches == 0 && pending_results.size() == 0)
         $display("ip_range_binary_search_lookup: match");
      else
         $display("ip_range_binary_search_lookup: mismatch");
      $finish;
   end

endmodule

[filelist.f]
hdl/irbs_pkg.sv
hdl/irbs_ctrl.sv
hdl/irbs_dpath.sv
hdl/ip_range_binary_search_lookup.sv
sim/ip_range_binary_search_lookup_test.sv
